[rtl/core/fraction_arith_reduce_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the fraction arithmetic block
// ---------------------------------------------------------------------------
`ifndef FRACTION_ARITH_REDUCE_ASSERT_SVH
`define FRACTION_ARITH_REDUCE_ASSERT_SVH

`ifndef SYNTH
// Implication or plain property, sampled on clk, off during reset
`define FRA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold
`define FRA_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FRA_ASSERT(label, clk, rst_n, prop, msg)
`define FRA_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[rtl/core/fra_pkg.sv]
// ---------------------------------------------------------------------------
// fra_pkg
// Shared widths, codes and stage payload types of the fraction pipeline.
// ---------------------------------------------------------------------------
package fra_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int IN_W          = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int RAW_W         = 2 * OPERAND_WIDTH + 1;
  localparam int MAG_W         = 2 * OPERAND_WIDTH;
  localparam int K_W           = $clog2(MAG_W) + 1;
  localparam int GCD_STAGES    = 2 * MAG_W;
  localparam int NUM_OUT_W     = 33;
  localparam int DEN_OUT_W     = 32;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef struct packed {
    status_e          status;
    logic             neg_n;
    logic             neg_d;
    logic [MAG_W-1:0] mag_n;
    logic [MAG_W-1:0] mag_d;
  } fra_mag_t;

  typedef struct packed {
    fra_mag_t         base;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [K_W-1:0]   k;
  } fra_gcd_t;

  typedef struct packed {
    status_e          status;
    logic             neg_n;
    logic             neg_d;
    logic [MAG_W-1:0] g;
    logic [MAG_W-1:0] dvd_n;
    logic [MAG_W-1:0] dvd_d;
    logic [MAG_W-1:0] rem_n;
    logic [MAG_W-1:0] rem_d;
    logic [MAG_W-1:0] quo_n;
    logic [MAG_W-1:0] quo_d;
  } fra_div_t;

endpackage

[rtl/core/fra_front.sv]
// ---------------------------------------------------------------------------
// fra_front
// Three stages: cross products, raw sum and status, signs and magnitudes.
// ---------------------------------------------------------------------------
module fra_front import fra_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [1:0]       kind_i,
  input  logic [IN_W-1:0]  num_a_i,
  input  logic [IN_W-1:0]  den_a_i,
  input  logic [IN_W-1:0]  num_b_i,
  input  logic [IN_W-1:0]  den_b_i,
  output logic             valid_o,
  output fra_mag_t         data_o
);

  logic signed [OPERAND_WIDTH-1:0] na, da, nb, db, mul_b, den_b;
  kind_e kind;

  logic                     v1_q, v2_q, v3_q;
  logic                     err1_q;
  kind_e                    kind1_q;
  logic signed [PROD_W-1:0] p0_d, p1_d, pd_d, p0_q, p1_q, pd_q;

  logic signed [RAW_W-1:0]  rn_d, rn2_q;
  logic signed [PROD_W-1:0] rd2_q;
  status_e                  st_d, st2_q;
  logic [RAW_W-1:0]         mag_n_full;
  logic [PROD_W-1:0]        mag_d_full;
  fra_mag_t                 d3_d, d3_q;

  // Take operands as signed and pick product partners
  assign kind  = kind_e'(kind_i);
  assign na    = OPERAND_WIDTH'(num_a_i);
  assign da    = OPERAND_WIDTH'(den_a_i);
  assign nb    = OPERAND_WIDTH'(num_b_i);
  assign db    = OPERAND_WIDTH'(den_b_i);
  assign mul_b = (kind == KIND_MUL) ? nb : db;
  assign den_b = (kind == KIND_DIV) ? nb : db;
  assign p0_d  = na * mul_b;
  assign p1_d  = nb * da;
  assign pd_d  = da * den_b;

  // Combine products into raw numerator and set status
  always_comb begin
    case (kind1_q)
      KIND_ADD: rn_d = {p0_q[PROD_W-1], p0_q} + {p1_q[PROD_W-1], p1_q};
      KIND_SUB: rn_d = {p0_q[PROD_W-1], p0_q} - {p1_q[PROD_W-1], p1_q};
      default:  rn_d = {p0_q[PROD_W-1], p0_q};
    endcase
    if (err1_q) begin
      st_d = ST_ERR;
    end else if (rn_d == '0 || pd_q == '0) begin
      st_d = ST_ZERO;
    end else begin
      st_d = ST_OK;
    end
  end

  // Take signs and magnitudes
  always_comb begin
    mag_n_full   = rn2_q[RAW_W-1] ? (~rn2_q + 1'b1) : rn2_q;
    mag_d_full   = rd2_q[PROD_W-1] ? (~rd2_q + 1'b1) : rd2_q;
    d3_d.status  = st2_q;
    d3_d.neg_n   = rn2_q[RAW_W-1];
    d3_d.neg_d   = rd2_q[PROD_W-1];
    d3_d.mag_n   = mag_n_full[MAG_W-1:0];
    d3_d.mag_d   = mag_d_full[MAG_W-1:0];
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      err1_q  <= (da == '0) || (db == '0) || (kind == KIND_DIV && nb == '0);
      kind1_q <= kind;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      pd_q    <= pd_d;
      rn2_q   <= rn_d;
      rd2_q   <= pd_q;
      st2_q   <= st_d;
      d3_q    <= d3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = d3_q;

endmodule

[rtl/core/fra_gcd_pipe.sv]
// ---------------------------------------------------------------------------
// fra_gcd_pipe
// Binary gcd, one reduction step per stage, over the two magnitudes.
// ---------------------------------------------------------------------------
module fra_gcd_pipe import fra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  fra_mag_t data_i,
  output logic     valid_o,
  output fra_gcd_t data_o
);

  logic     v_q [GCD_STAGES];
  fra_gcd_t s_q [GCD_STAGES];
  fra_gcd_t s_in [GCD_STAGES];
  fra_gcd_t s_d [GCD_STAGES];
  logic     v_in [GCD_STAGES];

  // Load magnitudes into the first step
  always_comb begin
    s_in[0].base = data_i;
    s_in[0].a    = data_i.mag_n;
    s_in[0].b    = data_i.mag_d;
    s_in[0].k    = '0;
    v_in[0]      = valid_i;
  end

  for (genvar i = 0; i < GCD_STAGES; i++) begin : g_step
    if (i > 0) begin : g_link
      assign s_in[i] = s_q[i-1];
      assign v_in[i] = v_q[i-1];
    end

    // One Stein step: shift out twos or halve the difference of odds
    always_comb begin
      s_d[i] = s_in[i];
      if (s_in[i].a == '0 || s_in[i].b == '0) begin
        s_d[i] = s_in[i];
      end else if (!s_in[i].a[0] && !s_in[i].b[0]) begin
        s_d[i].a = s_in[i].a >> 1;
        s_d[i].b = s_in[i].b >> 1;
        s_d[i].k = s_in[i].k + 1'b1;
      end else if (!s_in[i].a[0]) begin
        s_d[i].a = s_in[i].a >> 1;
      end else if (!s_in[i].b[0]) begin
        s_d[i].b = s_in[i].b >> 1;
      end else if (s_in[i].a >= s_in[i].b) begin
        s_d[i].a = (s_in[i].a - s_in[i].b) >> 1;
      end else begin
        s_d[i].b = (s_in[i].b - s_in[i].a) >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (adv_i) begin
        v_q[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        s_q[i] <= s_d[i];
      end
    end
  end

  assign valid_o = v_q[GCD_STAGES-1];
  assign data_o  = s_q[GCD_STAGES-1];

endmodule

[rtl/core/fra_div_pipe.sv]
// ---------------------------------------------------------------------------
// fra_div_pipe
// Rebuilds the gcd, then divides both magnitudes by it, one bit a stage.
// ---------------------------------------------------------------------------
module fra_div_pipe import fra_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  fra_gcd_t data_i,
  output logic     valid_o,
  output fra_div_t data_o
);

  localparam int NSTG = MAG_W + 1;

  logic     v_q [NSTG];
  fra_div_t s_q [NSTG];
  fra_div_t s_d [NSTG];

  // Form gcd from the odd part and the shared power of two
  always_comb begin
    s_d[0].status = data_i.base.status;
    s_d[0].neg_n  = data_i.base.neg_n;
    s_d[0].neg_d  = data_i.base.neg_d;
    s_d[0].g      = (data_i.a | data_i.b) << data_i.k;
    s_d[0].dvd_n  = data_i.base.mag_n;
    s_d[0].dvd_d  = data_i.base.mag_d;
    s_d[0].rem_n  = '0;
    s_d[0].rem_d  = '0;
    s_d[0].quo_n  = '0;
    s_d[0].quo_d  = '0;
  end

  for (genvar i = 1; i < NSTG; i++) begin : g_bit
    localparam int BIT = MAG_W - i;
    logic [MAG_W:0] try_n, try_d;

    // Restoring step on the next dividend bit of both magnitudes
    always_comb begin
      s_d[i] = s_q[i-1];
      try_n  = {s_q[i-1].rem_n, s_q[i-1].dvd_n[BIT]};
      try_d  = {s_q[i-1].rem_d, s_q[i-1].dvd_d[BIT]};
      if (try_n >= {1'b0, s_q[i-1].g}) begin
        try_n           = try_n - {1'b0, s_q[i-1].g};
        s_d[i].quo_n[BIT] = 1'b1;
      end
      if (try_d >= {1'b0, s_q[i-1].g}) begin
        try_d           = try_d - {1'b0, s_q[i-1].g};
        s_d[i].quo_d[BIT] = 1'b1;
      end
      s_d[i].rem_n = try_n[MAG_W-1:0];
      s_d[i].rem_d = try_d[MAG_W-1:0];
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (adv_i) begin
        v_q[i] <= (i == 0) ? valid_i : v_q[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        s_q[i] <= s_d[i];
      end
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign data_o  = s_q[NSTG-1];

endmodule

[rtl/core/fraction_arith_reduce.sv]
// Pipeline from the accepting edge to result valid: 3 front stages, 64 gcd
// steps, 1 gcd rebuild, 32 divide bits, 1 sign and output stage.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register waits for out_ready_i.
// Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
// fraction_arith_reduce
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by the gcd of its magnitudes.
// ---------------------------------------------------------------------------
`include "fraction_arith_reduce_assert.svh"

module fraction_arith_reduce import fra_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [IN_W-1:0]      num_a_i,
  input  logic [IN_W-1:0]      den_a_i,
  input  logic [IN_W-1:0]      num_b_i,
  input  logic [IN_W-1:0]      den_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [NUM_OUT_W-1:0] result_num_o,
  output logic [DEN_OUT_W-1:0] result_den_o
);

  logic                 adv;
  logic                 f_valid, g_valid, d_valid;
  fra_mag_t             f_data;
  fra_gcd_t             g_data;
  fra_div_t             d_data;
  logic                 out_valid_q;
  status_e              status_q;
  logic [NUM_OUT_W-1:0] num_d, num_q, num_ext;
  logic [DEN_OUT_W-1:0] den_d, den_q, den_ext;

  // Advance the whole pipeline unless a result is stuck at the output
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  fra_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .kind_i  (kind_i),
    .num_a_i (num_a_i),
    .den_a_i (den_a_i),
    .num_b_i (num_b_i),
    .den_b_i (den_b_i),
    .valid_o (f_valid),
    .data_o  (f_data)
  );

  fra_gcd_pipe u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_valid),
    .data_i  (f_data),
    .valid_o (g_valid),
    .data_o  (g_data)
  );

  fra_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (g_valid),
    .data_i  (g_data),
    .valid_o (d_valid),
    .data_o  (d_data)
  );

  // Apply signs; zero the fields for zero and error items
  always_comb begin
    num_ext = NUM_OUT_W'(d_data.quo_n);
    den_ext = DEN_OUT_W'(d_data.quo_d);
    num_d   = d_data.neg_n ? (~num_ext + 1'b1) : num_ext;
    den_d   = d_data.neg_d ? (~den_ext + 1'b1) : den_ext;
    if (d_data.status != ST_OK) begin
      num_d = '0;
      den_d = '0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= d_data.status;
      num_q    <= num_d;
      den_q    <= den_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign result_num_o = num_q;
  assign result_den_o = den_q;

  `FRA_NEVER(a_no_accept_on_stall, clk_i, rst_ni,
             in_valid_i && in_ready_o && out_valid_o && !out_ready_i,
             "item accepted while output stalled")
  `FRA_ASSERT(a_zero_fields, clk_i, rst_ni,
              out_valid_o && status_o != ST_OK |-> result_num_o == '0 && result_den_o == '0,
              "fields not cleared on zero or error")
  `FRA_ASSERT(a_den_nonzero, clk_i, rst_ni,
              out_valid_o && status_o == ST_OK |-> result_den_o != '0 && result_num_o != '0,
              "reduced fraction has a zero part")

endmodule
